[src/cbf_pkg.sv]
`timescale 1ns / 1ps
package cbf_pkg;

	localparam logic OP_START = 1'b0;
	localparam logic OP_DATA  = 1'b1;

	localparam logic [1:0] TYPE_ML = 2'd2;

	localparam logic [1:0] REG_LONG_LEADER  = 2'd0;
	localparam logic [1:0] REG_SHORT_LEADER = 2'd1;
	localparam logic [1:0] REG_MAX_BLOCK    = 2'd2;

	localparam logic [7:0] LONG_LEADER_RST  = 8'd90;
	localparam logic [7:0] SHORT_LEADER_RST = 8'd10;
	localparam logic [7:0] MAX_BLOCK_RST    = 8'd255;

	localparam int NAME_MAX       = 8;
	localparam int NAME_BITS      = 8 * NAME_MAX;
	localparam int HDR_FIELD_BYTES = 17;

	localparam logic [7:0] BYTE_LEADER   = 8'hff;
	localparam logic [7:0] BYTE_SYNC1    = 8'h01;
	localparam logic [7:0] BYTE_SYNC2    = 8'h3c;
	localparam logic [7:0] BYTE_HDR_TYPE = 8'h00;
	localparam logic [7:0] BYTE_BLK_TYPE = 8'h01;
	localparam logic [7:0] BYTE_HDR_LEN  = 8'h14;
	localparam logic [7:0] BYTE_SPACE    = 8'h20;
	localparam logic [7:0] BYTE_SIGN     = 8'h80;
	localparam logic [7:0] BYTE_ZERO     = 8'h00;
	localparam logic [7:0] TRAIL_LEN     = 8'd4;

	typedef struct packed {
		logic                 operation;
		logic [NAME_BITS-1:0] file_name;
		logic [1:0]           file_type;
		logic [23:0]          total_length;
		logic [7:0]           data_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [7:0] repeat_count;
		logic       run_last;
	} result_t;

	// one unit of work for the run sequencer
	typedef struct packed {
		logic                 is_header;
		logic [NAME_BITS-1:0] file_name;
		logic [1:0]           file_type;
		logic                 start_blk;
		logic                 end_blk;
		logic                 footer;
		logic [7:0]           blk_len;
		logic [7:0]           data_byte;
		logic [7:0]           lead;
		logic [7:0]           lead_foot;
	} cmd_t;

	typedef struct packed {
		logic cmd_push;
		logic in_file;
	} front_stat_t;

	typedef struct packed {
		logic cmd_pop;
		logic run_load;
		logic run_last;
	} back_stat_t;

endpackage

[src/cbf_front.sv]
`timescale 1ns / 1ps
module cbf_front import cbf_pkg::*; #(
	parameter int LENGTH_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  item_t       item,
	input  logic        cmd_full,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output cmd_t        cmd,
	output front_stat_t stat
);

	logic [7:0]             long_lead_q, short_lead_q, max_blk_q;
	logic [1:0]             type_q;
	logic [LENGTH_BITS-1:0] rem_q;
	logic [7:0]             len_q, pos_q;
	logic                   done_q;

	logic                   accept, in_file, first, is_ml, blk_end;
	logic [31:0]            total_ext;
	logic [LENGTH_BITS-1:0] total_len, lim_ext;
	logic [7:0]             lim, n_new, blk_n, pos_nxt;

	assign accept    = push && !cmd_full;
	assign in_file   = rem_q != '0;
	assign first     = pos_q == 8'd0;
	assign is_ml     = type_q == TYPE_ML;
	assign total_ext = {8'd0, item.total_length};
	assign total_len = total_ext[LENGTH_BITS-1:0];
	assign lim       = (max_blk_q == 8'd0) ? 8'd1 : max_blk_q;
	assign lim_ext   = LENGTH_BITS'(lim);
	assign n_new     = (rem_q < lim_ext) ? rem_q[7:0] : lim;
	assign blk_n     = first ? n_new : len_q;
	assign pos_nxt   = pos_q + 8'd1;
	assign blk_end   = pos_nxt >= blk_n;

	always_comb begin
		cmd = '0;
		if (item.operation == OP_START) begin
			cmd.is_header = 1'b1;
			cmd.file_name = item.file_name;
			cmd.file_type = item.file_type;
			cmd.lead      = long_lead_q;
			cmd.lead_foot = (item.file_type == TYPE_ML) ? short_lead_q : long_lead_q;
			cmd.footer    = total_len == '0;
		end else begin
			cmd.file_type = type_q;
			cmd.start_blk = first;
			cmd.end_blk   = blk_end;
			cmd.footer    = rem_q == LENGTH_BITS'(1);
			cmd.blk_len   = blk_n;
			cmd.data_byte = item.data_byte;
			// later machine-code blocks take the short leader
			cmd.lead      = (is_ml && done_q) ? short_lead_q : long_lead_q;
			cmd.lead_foot = is_ml ? short_lead_q : long_lead_q;
		end
	end

	assign stat.cmd_push = accept && (item.operation == OP_START || in_file);
	assign stat.in_file  = in_file;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_lead_q  <= LONG_LEADER_RST;
			short_lead_q <= SHORT_LEADER_RST;
			max_blk_q    <= MAX_BLOCK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LONG_LEADER:  long_lead_q  <= cfg_data;
				REG_SHORT_LEADER: short_lead_q <= cfg_data;
				REG_MAX_BLOCK:    max_blk_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q <= '0;
			rem_q  <= '0;
			len_q  <= '0;
			pos_q  <= '0;
			done_q <= 1'b0;
		end else if (accept) begin
			if (item.operation == OP_START) begin
				type_q <= item.file_type;
				rem_q  <= total_len;
				len_q  <= '0;
				pos_q  <= '0;
				done_q <= 1'b0;
			end else if (in_file) begin
				len_q <= blk_n;
				rem_q <= rem_q - LENGTH_BITS'(1);
				if (blk_end) begin
					pos_q  <= '0;
					done_q <= 1'b1;
				end else begin
					pos_q <= pos_nxt;
				end
			end
		end
	end

endmodule

[src/cbf_cmd_fifo.sv]
`timescale 1ns / 1ps
module cbf_cmd_fifo import cbf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr,
	input  cmd_t       wr_cmd,
	input  back_stat_t bk_stat,
	output cmd_t       rd_cmd,
	output logic       full,
	output logic       avail
);

	cmd_t       ent_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       rd;

	assign full   = cnt_q == 2'd2;
	assign avail  = cnt_q != 2'd0;
	assign rd     = bk_stat.cmd_pop && avail;
	assign rd_cmd = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr && !full) begin
			ent_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr && !full) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'((wr && !full) ? 1 : 0) - 2'(rd ? 1 : 0);
		end
	end

endmodule

[src/cbf_back.sv]
`timescale 1ns / 1ps
module cbf_back import cbf_pkg::*; #(
	parameter int NAME_CHARS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  logic       avail,
	input  logic       pop,
	output result_t    result,
	output logic       empty,
	output back_stat_t stat
);

	localparam logic [4:0] S_BEGIN  = 5'd0;
	localparam logic [4:0] S_HLEAD  = 5'd1;
	localparam logic [4:0] S_HSYNC1 = 5'd2;
	localparam logic [4:0] S_HSYNC2 = 5'd3;
	localparam logic [4:0] S_HTYP   = 5'd4;
	localparam logic [4:0] S_HLEN   = 5'd5;
	localparam logic [4:0] S_HNAME  = 5'd6;
	localparam logic [4:0] S_HFT    = 5'd7;
	localparam logic [4:0] S_HFL1   = 5'd8;
	localparam logic [4:0] S_HFL2   = 5'd9;
	localparam logic [4:0] S_HZERO  = 5'd10;
	localparam logic [4:0] S_CSUM   = 5'd11;
	localparam logic [4:0] S_TRAIL  = 5'd12;
	localparam logic [4:0] S_BLEAD  = 5'd13;
	localparam logic [4:0] S_BSYNC1 = 5'd14;
	localparam logic [4:0] S_BSYNC2 = 5'd15;
	localparam logic [4:0] S_BTYP   = 5'd16;
	localparam logic [4:0] S_BLEN   = 5'd17;
	localparam logic [4:0] S_BYTE   = 5'd18;
	localparam logic [4:0] S_FLEAD  = 5'd19;
	localparam logic [4:0] S_FSYNC1 = 5'd20;
	localparam logic [4:0] S_FSYNC2 = 5'd21;
	localparam logic [4:0] S_FFF1   = 5'd22;
	localparam logic [4:0] S_F00    = 5'd23;
	localparam logic [4:0] S_FFF2   = 5'd24;
	localparam logic [4:0] S_FTRAIL = 5'd25;

	logic [4:0]  step_q, cur, nxt;
	logic [3:0]  idx_q;
	logic [7:0]  sum_q;
	result_t     out_q;
	logic        out_valid_q;

	logic [7:0]  chars [NAME_MAX];
	logic [7:0]  ch, flag, rb, rc;
	logic [15:0] prod;
	logic        ch_ok, add_sum, clr_sum, fin, idx_inc, idx_clr;
	logic        emit, take, go;

	always_comb begin
		for (int k = 0; k < NAME_MAX; k++) begin
			chars[k] = cmd.file_name[NAME_BITS-1-8*k -: 8];
		end
	end

	assign ch    = (idx_q < 4'(NAME_CHARS)) ? chars[idx_q[2:0]] : BYTE_ZERO;
	assign ch_ok = (idx_q < 4'(NAME_CHARS)) && (ch > BYTE_SPACE) && (ch < BYTE_SIGN);
	assign flag  = (cmd.file_type == TYPE_ML) ? BYTE_ZERO : BYTE_LEADER;

	always_comb begin
		if (step_q == S_BEGIN) begin
			cur = cmd.is_header ? S_HLEAD : (cmd.start_blk ? S_BLEAD : S_BYTE);
		end else begin
			cur = step_q;
		end
	end

	always_comb begin
		rb      = BYTE_ZERO;
		rc      = 8'd0;
		add_sum = 1'b0;
		clr_sum = 1'b0;
		fin     = 1'b0;
		idx_inc = 1'b0;
		idx_clr = 1'b0;
		nxt     = cur;
		unique case (cur)
			S_HLEAD: begin
				rb = BYTE_LEADER; rc = cmd.lead; nxt = S_HSYNC1;
			end
			S_HSYNC1: begin
				rb = BYTE_SYNC1; rc = 8'd1; nxt = S_HSYNC2;
			end
			S_HSYNC2: begin
				rb = BYTE_SYNC2; rc = 8'd1; nxt = S_HTYP;
			end
			S_HTYP: begin
				rb = BYTE_HDR_TYPE; rc = 8'd1; add_sum = 1'b1; clr_sum = 1'b1;
				idx_clr = 1'b1; nxt = S_HLEN;
			end
			S_HLEN: begin
				rb = BYTE_HDR_LEN; rc = 8'd1; add_sum = 1'b1; nxt = S_HNAME;
			end
			S_HNAME: begin
				add_sum = 1'b1;
				if (ch_ok) begin
					rb = ch; rc = 8'd1; idx_inc = 1'b1;
				end else begin
					// pad the rest of the name with spaces
					rb  = BYTE_SPACE;
					rc  = 8'(NAME_CHARS) - {4'd0, idx_q};
					nxt = S_HFT;
				end
			end
			S_HFT: begin
				rb = {6'd0, cmd.file_type}; rc = 8'd1; add_sum = 1'b1; nxt = S_HFL1;
			end
			S_HFL1: begin
				rb = flag; rc = 8'd1; add_sum = 1'b1; nxt = S_HFL2;
			end
			S_HFL2: begin
				rb = flag; rc = 8'd1; add_sum = 1'b1; nxt = S_HZERO;
			end
			S_HZERO: begin
				rb = BYTE_ZERO; rc = 8'(HDR_FIELD_BYTES - NAME_CHARS); add_sum = 1'b1;
				nxt = S_CSUM;
			end
			S_CSUM: begin
				rb = sum_q; rc = 8'd1; nxt = S_TRAIL;
			end
			S_TRAIL: begin
				rb = BYTE_ZERO; rc = TRAIL_LEN;
				if (cmd.footer) nxt = S_FLEAD;
				else fin = 1'b1;
			end
			S_BLEAD: begin
				rb = BYTE_LEADER; rc = cmd.lead; nxt = S_BSYNC1;
			end
			S_BSYNC1: begin
				rb = BYTE_SYNC1; rc = 8'd1; nxt = S_BSYNC2;
			end
			S_BSYNC2: begin
				rb = BYTE_SYNC2; rc = 8'd1; nxt = S_BTYP;
			end
			S_BTYP: begin
				rb = BYTE_BLK_TYPE; rc = 8'd1; add_sum = 1'b1; clr_sum = 1'b1; nxt = S_BLEN;
			end
			S_BLEN: begin
				rb = cmd.blk_len; rc = 8'd1; add_sum = 1'b1; nxt = S_BYTE;
			end
			S_BYTE: begin
				rb = cmd.data_byte; rc = 8'd1; add_sum = 1'b1;
				if (cmd.end_blk) nxt = S_CSUM;
				else if (cmd.footer) nxt = S_FLEAD;
				else fin = 1'b1;
			end
			S_FLEAD: begin
				rb = BYTE_LEADER; rc = cmd.lead_foot; nxt = S_FSYNC1;
			end
			S_FSYNC1: begin
				rb = BYTE_SYNC1; rc = 8'd1; nxt = S_FSYNC2;
			end
			S_FSYNC2: begin
				rb = BYTE_SYNC2; rc = 8'd1; nxt = S_FFF1;
			end
			S_FFF1: begin
				rb = BYTE_LEADER; rc = 8'd1; nxt = S_F00;
			end
			S_F00: begin
				rb = BYTE_ZERO; rc = 8'd1; nxt = S_FFF2;
			end
			S_FFF2: begin
				rb = BYTE_LEADER; rc = 8'd1; nxt = S_FTRAIL;
			end
			S_FTRAIL: begin
				rb = BYTE_ZERO; rc = TRAIL_LEN; fin = 1'b1;
			end
			default: begin
				nxt = S_BEGIN;
			end
		endcase
	end

	// a run of zero length is skipped without using the output stage
	assign emit = rc != 8'd0;
	assign take = pop && out_valid_q;
	assign go   = avail && (!out_valid_q || take || !emit);
	assign prod = rb * rc;

	assign stat.cmd_pop  = go && fin;
	assign stat.run_load = go && emit;
	assign stat.run_last = fin;

	assign result = out_q;
	assign empty  = !out_valid_q;

	always_ff @(posedge clk) begin
		if (go && emit) begin
			out_q.out_byte     <= rb;
			out_q.repeat_count <= rc;
			out_q.run_last     <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= S_BEGIN;
			idx_q       <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (go && emit) begin
				out_valid_q <= 1'b1;
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
			if (go) begin
				step_q <= fin ? S_BEGIN : nxt;
				if (idx_clr) idx_q <= '0;
				else if (idx_inc) idx_q <= idx_q + 4'd1;
				if (add_sum) sum_q <= (clr_sum ? 8'd0 : sum_q) + prod[7:0];
			end
		end
	end

endmodule

[src/cassette_block_framer.sv]
`timescale 1ns / 1ps
// Tape image framer for the cassette block format with sync bytes 01 3C. Each
// accepted item is turned into runs of (out_byte, repeat_count); run_last marks
// the final run of an item. A start item gives the header block, up to 19 runs,
// plus the 7-run footer when the file is empty. A data byte in the middle of a
// block gives one run, so a steady stream moves one item per clock when not
// stalled. The first byte of a block adds 5 prefix runs, the last byte 2 runs
// for checksum and trailer, the final byte of the file 7 footer runs. The run
// sequencer in the back end issues one run per clock when not stalled; a run of
// zero length (leader register 0, or a name with no padding) gives no output. A
// two-entry command queue sits between classifier and sequencer, so items keep
// being taken while a block boundary is being written out. Data items outside a
// file are taken and dropped. Write configuration only while the block is idle.
module cassette_block_framer import cbf_pkg::*; #(
	parameter int NAME_CHARS  = 8,
	parameter int LENGTH_BITS = 24
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  item_t      item,
	output logic       empty,
	input  logic       pop,
	output result_t    result,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	cmd_t        fr_cmd, bk_cmd;
	front_stat_t fr_stat;
	back_stat_t  bk_stat;
	logic        cmd_avail;

	cbf_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.cmd_full (full),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (fr_cmd),
		.stat     (fr_stat)
	);

	cbf_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (fr_stat.cmd_push),
		.wr_cmd (fr_cmd),
		.bk_stat(bk_stat),
		.rd_cmd (bk_cmd),
		.full   (full),
		.avail  (cmd_avail)
	);

	cbf_back #(
		.NAME_CHARS(NAME_CHARS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (bk_cmd),
		.avail  (cmd_avail),
		.pop    (pop),
		.result (result),
		.empty  (empty),
		.stat   (bk_stat)
	);

`ifndef ASSERT_OFF
	a_no_empty_run: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.repeat_count != 8'd0)
		else $error("run of zero length on the result port");

	a_last_on_retire: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.cmd_pop |-> (bk_stat.run_load && bk_stat.run_last))
		else $error("command retired without a final run");

	a_drop_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && item.operation == OP_DATA && !fr_stat.in_file)
		|-> !fr_stat.cmd_push)
		else $error("data item outside a file produced work");
`endif

endmodule

[bench/cbf_checker.sv]
`timescale 1ns / 1ps
module cbf_checker import cbf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  item_t      item,
	input  logic       empty,
	input  logic       pop,
	input  result_t    result,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	output int         fail_count,
	output int         runs_pending
);

	localparam logic [7:0] MARK_FF = 8'hff;

	// register copies
	logic [7:0]  lead_long;
	logic [7:0]  lead_short;
	logic [7:0]  blk_max;

	// framing state
	logic [1:0]  file_kind;
	logic [23:0] bytes_left;
	logic [7:0]  blk_size;
	logic [7:0]  blk_fill;
	logic [7:0]  csum;
	bit          past_first_blk;

	result_t     item_runs[$];
	result_t     runs_due[$];
	int          run_no;

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic add_run(input logic [7:0] val, input logic [7:0] n);
		result_t r;
		if (n != 8'd0) begin
			r.out_byte     = val;
			r.repeat_count = n;
			r.run_last     = 1'b0;
			item_runs = {item_runs, r};
		end
	endtask

	task automatic add_summed(input logic [7:0] val, input logic [7:0] n);
		csum = csum + val * n;
		add_run(val, n);
	endtask

	task automatic sync_runs();
		add_run(BYTE_SYNC1, 8'd1);
		add_run(BYTE_SYNC2, 8'd1);
	endtask

	task automatic footer_runs();
		add_run(BYTE_LEADER, (file_kind == TYPE_ML) ? lead_short : lead_long);
		sync_runs();
		add_run(MARK_FF, 8'd1);
		add_run(BYTE_ZERO, 8'd1);
		add_run(MARK_FF, 8'd1);
		add_run(BYTE_ZERO, TRAIL_LEN);
	endtask

	task automatic header_runs(input logic [NAME_BITS-1:0] name);
		logic [7:0] flag;
		logic [7:0] ch;
		int         k;
		int         used;
		bit         stop;
		flag = (file_kind == TYPE_ML) ? BYTE_ZERO : MARK_FF;
		add_run(BYTE_LEADER, lead_long);
		sync_runs();
		csum = 8'd0;
		add_summed(BYTE_HDR_TYPE, 8'd1);
		add_summed(BYTE_HDR_LEN, 8'd1);
		used = 0;
		stop = 1'b0;
		// copy characters up to the first control, space or signed byte
		for (k = 0; k < NAME_MAX; k++) begin
			ch = name[NAME_BITS-1-8*k -: 8];
			if (!stop && ch > BYTE_SPACE && ch < BYTE_SIGN) begin
				add_summed(ch, 8'd1);
				used++;
			end else begin
				stop = 1'b1;
			end
		end
		add_summed(BYTE_SPACE, 8'(NAME_MAX - used));
		add_summed({6'd0, file_kind}, 8'd1);
		add_summed(flag, 8'd1);
		add_summed(flag, 8'd1);
		add_summed(BYTE_ZERO, 8'(HDR_FIELD_BYTES - NAME_MAX));
		add_run(csum, 8'd1);
		add_run(BYTE_ZERO, TRAIL_LEN);
	endtask

	task automatic data_runs(input logic [7:0] val);
		logic [23:0] cap;
		logic [23:0] n;
		if (blk_fill == 8'd0) begin
			cap = (blk_max == 8'd0) ? 24'd1 : {16'd0, blk_max};
			n = (bytes_left < cap) ? bytes_left : cap;
			blk_size = n[7:0];
			add_run(BYTE_LEADER,
				(file_kind == TYPE_ML && past_first_blk) ? lead_short : lead_long);
			sync_runs();
			csum = 8'd0;
			add_summed(BYTE_BLK_TYPE, 8'd1);
			add_summed(blk_size, 8'd1);
		end
		add_summed(val, 8'd1);
		blk_fill = blk_fill + 8'd1;
		bytes_left = bytes_left - 24'd1;
		if (blk_fill >= blk_size) begin
			add_run(csum, 8'd1);
			add_run(BYTE_ZERO, TRAIL_LEN);
			blk_fill = 8'd0;
			past_first_blk = 1'b1;
		end
		if (bytes_left == 24'd0)
			footer_runs();
	endtask

	task automatic predict_item(input item_t it);
		int n;
		item_runs.delete();
		if (it.operation == OP_START) begin
			file_kind      = it.file_type;
			bytes_left     = it.total_length;
			blk_size       = 8'd0;
			blk_fill       = 8'd0;
			past_first_blk = 1'b0;
			header_runs(it.file_name);
			if (bytes_left == 24'd0)
				footer_runs();
		end else if (bytes_left != 24'd0) begin
			data_runs(it.data_byte);
		end
		n = item_runs.size();
		if (n != 0)
			item_runs[n-1].run_last = 1'b1;
		runs_due = {runs_due, item_runs};
	endtask

	task automatic check_run(input result_t got);
		result_t want;
		if (runs_due.size() == 0) begin
			report_mismatch($sformatf("run %0d arrived with none due: byte %h count %0d last %b",
				run_no, got.out_byte, got.repeat_count, got.run_last));
		end else begin
			want = runs_due.pop_front();
			if (got.out_byte !== want.out_byte)
				report_mismatch($sformatf("run %0d out_byte %h, want %h",
					run_no, got.out_byte, want.out_byte));
			if (got.repeat_count !== want.repeat_count)
				report_mismatch($sformatf("run %0d repeat_count %0d, want %0d",
					run_no, got.repeat_count, want.repeat_count));
			if (got.run_last !== want.run_last)
				report_mismatch($sformatf("run %0d run_last %b, want %b",
					run_no, got.run_last, want.run_last));
		end
		run_no++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_long      = LONG_LEADER_RST;
			lead_short     = SHORT_LEADER_RST;
			blk_max        = MAX_BLOCK_RST;
			file_kind      = 2'd0;
			bytes_left     = 24'd0;
			blk_size       = 8'd0;
			blk_fill       = 8'd0;
			csum           = 8'd0;
			past_first_blk = 1'b0;
			run_no         = 0;
			fail_count     = 0;
			runs_due.delete();
			runs_pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LONG_LEADER:  lead_long  = cfg_data;
					REG_SHORT_LEADER: lead_short = cfg_data;
					REG_MAX_BLOCK:    blk_max    = cfg_data;
					default: ;
				endcase
			end
			// check before predicting, so a beat taken at this edge never matches its own item
			if (pop && !empty)
				check_run(result);
			if (push && !full)
				predict_item(item);
			runs_pending <= runs_due.size();
		end
	end

endmodule

[bench/cassette_block_framer_test.sv]
`timescale 1ns / 1ps
module cassette_block_framer_test;
	import cbf_pkg::*;

	localparam logic [1:0] KIND_BASIC = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_ODD   = 2'd3;
	localparam int PHASE_ITEMS = 18;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       push;
	logic       full;
	item_t      item;
	logic       empty;
	logic       pop;
	result_t    result;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	int         fail_count;
	int         runs_pending;

	bit          tx_gaps = 1'b1;
	bit          rx_gaps = 1'b1;
	bit          hold_long = 1'b0;
	logic [23:0] data_left = 24'd0;
	int          items_sent = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	cassette_block_framer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	cbf_checker framer_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.item         (item),
		.empty        (empty),
		.pop          (pop),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.runs_pending (runs_pending)
	);

	function automatic item_t filler();
		item_t it;
		it.operation    = OP_DATA;
		it.file_name    = {$urandom, $urandom};
		it.file_type    = 2'($urandom);
		it.total_length = 24'($urandom);
		it.data_byte    = 8'($urandom);
		return it;
	endfunction

	function automatic logic [NAME_BITS-1:0] rand_name();
		logic [NAME_BITS-1:0] nm;
		int                   k;
		int                   cut;
		for (k = 0; k < NAME_MAX; k++)
			nm[NAME_BITS-1-8*k -: 8] = 8'($urandom_range(8'h21, 8'h7f));
		case ($urandom_range(0, 2))
			0: ;
			1: begin
				// terminate early with a control/space or a signed byte
				cut = $urandom_range(0, NAME_MAX - 1);
				nm[NAME_BITS-1-8*cut -: 8] = $urandom_range(0, 1) ?
					8'($urandom_range(0, 8'h20)) : 8'($urandom_range(8'h80, 8'hff));
			end
			default: nm = {$urandom, $urandom};
		endcase
		return nm;
	endfunction

	function automatic logic [23:0] rand_len();
		if ($urandom_range(0, 7) == 0)
			return 24'($urandom_range(13, 40));
		return 24'($urandom_range(0, 12));
	endfunction

	function automatic logic [7:0] rand_reg();
		case ($urandom_range(0, 4))
			0: return 8'd1;
			1: return 8'd255;
			2: return 8'd0;
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	task automatic send_item(input item_t it);
		if (tx_gaps && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		item <= it;
		push <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic start_file(input logic [NAME_BITS-1:0] nm, input logic [1:0] kind,
		input logic [23:0] len);
		item_t it;
		it = filler();
		it.operation    = OP_START;
		it.file_name    = nm;
		it.file_type    = kind;
		it.total_length = len;
		send_item(it);
		data_left = len;
		items_sent++;
	endtask

	task automatic send_data(input logic [7:0] val);
		item_t it;
		it = filler();
		it.operation = OP_DATA;
		it.data_byte = val;
		send_item(it);
		// data outside a file is dropped and does not count
		if (data_left != 24'd0) begin
			data_left = data_left - 24'd1;
			items_sent++;
		end
	endtask

	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (runs_pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] long_len, input logic [7:0] short_len,
		input logic [7:0] blk_len);
		cfg_we    <= 1'b1;
		cfg_index <= REG_LONG_LEADER;
		cfg_data  <= long_len;
		@(posedge clk);
		cfg_index <= REG_SHORT_LEADER;
		cfg_data  <= short_len;
		@(posedge clk);
		cfg_index <= REG_MAX_BLOCK;
		cfg_data  <= blk_len;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_files(input int goal);
		int stop_at;
		stop_at = items_sent + goal;
		while (items_sent < stop_at) begin
			if (data_left == 24'd0) begin
				if ($urandom_range(0, 9) == 0)
					send_data(8'($urandom));
				start_file(rand_name(), 2'($urandom_range(0, 3)), rand_len());
			end else if ($urandom_range(0, 29) == 0) begin
				// abandon the file in progress
				start_file(rand_name(), 2'($urandom_range(0, 3)), rand_len());
			end else begin
				send_data(8'($urandom));
			end
		end
		while (data_left != 24'd0)
			send_data(8'($urandom));
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_long) begin
				pop <= 1'b0;
				hold_long = 1'b0;
				repeat (300) @(posedge clk);
			end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		#4_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n    <= 1'b0;
		push      <= 1'b0;
		item      <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_LONG_LEADER;
		cfg_data  <= 8'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings
		send_data(8'h5a);
		start_file("TAPEFILE", KIND_BASIC, 24'd0);
		start_file({8'h21, 8'h7f, 8'h20, "ZZZZZ"}, TYPE_ML, 24'd3);
		send_data(8'h00);
		send_data(8'hff);
		send_data(8'h80);
		start_file({8'h80, "ABCDEFG"}, KIND_DATA, 24'd2);
		send_data(8'h01);
		start_file({NAME_BITS{1'b1}}, KIND_ODD, 24'd1);
		send_data(8'haa);
		start_file({NAME_BITS{1'b0}}, KIND_ODD, 24'hffffff);
		send_data(8'h55);
		start_file({"AB", 8'h00, "CDEFG"}, KIND_BASIC, 24'd0);
		settle();

		// zero leaders; zero block length means one byte per block
		set_config(8'd0, 8'd0, 8'd0);
		start_file("MCODE", TYPE_ML, 24'd3);
		send_data(8'h10);
		send_data(8'h20);
		send_data(8'h30);
		start_file("BAS", KIND_BASIC, 24'd2);
		send_data(8'hfe);
		send_data(8'h7f);
		settle();

		set_config(8'd255, 8'd1, 8'd2);
		start_file("LOADER", TYPE_ML, 24'd5);
		repeat (5) send_data(8'($urandom));
		settle();

		// fill the block against a stalled receiver
		set_config(8'd255, 8'd255, 8'd1);
		hold_long = 1'b1;
		random_files(PHASE_ITEMS);
		settle();

		set_config(rand_reg(), rand_reg(), 8'($urandom_range(1, 8)));
		random_files(PHASE_ITEMS);
		settle();

		set_config(8'd1, 8'd1, 8'd255);
		random_files(PHASE_ITEMS);
		settle();

		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		set_config(rand_reg(), rand_reg(), rand_reg());
		random_files(PHASE_ITEMS);
		settle();

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
